// ===== rtl/alarm_clock_set_controller_assert.svh =====
// Assertion macros used by the skid stage of the alarm clock set controller RTL.
`ifndef ALARM_CLOCK_SET_CONTROLLER_ASSERT_SVH
`define ALARM_CLOCK_SET_CONTROLLER_ASSERT_SVH

// Same-cycle implication, checked at every rising clk edge outside reset.
`define ACSC_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, checked at every rising clk edge outside reset.
`define ACSC_ASSERT_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("%m: next-cycle check failed");

`endif

// ===== rtl/acsc_pkg.sv =====
// Types, codes, constants and BCD helpers of the alarm clock set controller.
`default_nettype none

package acsc_pkg;

    // Display and edit modes
    typedef enum logic [2:0] {
        MODE_UNCONF = 3'd0,
        MODE_SHOW   = 3'd1,
        MODE_TMIN   = 3'd2,
        MODE_THOUR  = 3'd3,
        MODE_AMIN   = 3'd4,
        MODE_AHOUR  = 3'd5
    } acsc_mode_t;

    // Commands to the timekeeper
    typedef enum logic [2:0] {
        CMD_NONE        = 3'd0,
        CMD_WRITE_TIME  = 3'd1,
        CMD_WRITE_ALARM = 3'd2,
        CMD_ARM         = 3'd3,
        CMD_DISARM      = 3'd4,
        CMD_SNOOZE      = 3'd5
    } acsc_cmd_t;

    // Item operations
    typedef enum logic [1:0] {
        OP_KEY   = 2'd0,
        OP_TICK  = 2'd1,
        OP_ALARM = 2'd2,
        OP_NONE  = 2'd3
    } acsc_op_t;

    // Key bit positions in key_levels
    localparam int KEY_ACCEPT    = 0;
    localparam int KEY_CANCEL    = 1;
    localparam int KEY_UP        = 2;
    localparam int KEY_DOWN      = 3;
    localparam int KEY_SET_TIME  = 4;
    localparam int KEY_SET_ALARM = 5;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_SNOOZE_MINUTES = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDLE_TIMEOUT   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_SECONDS   = 2'd2;

    localparam logic [5:0] SNOOZE_RESET = 6'd5;
    localparam logic [7:0] IDLE_RESET   = 8'd30;
    localparam logic [3:0] HOLD_RESET   = 4'd3;

    // Digit limits of the minutes and hours pairs
    localparam logic [3:0] MIN_TENS_MAX   = 4'd5;
    localparam logic [3:0] MIN_UNITS_MAX  = 4'd9;
    localparam logic [3:0] HOUR_TENS_MAX  = 4'd2;
    localparam logic [3:0] HOUR_UNITS_MAX = 4'd3;
    localparam logic [5:0] SNOOZE_MAX     = 6'd59;

    typedef struct packed {
        logic [1:0]  operation;
        logic [5:0]  key_levels;
        logic        time_valid;
        logic [15:0] clock_time;
        logic [15:0] alarm_time;
    } acsc_in_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic        alarm_ringing;
        logic [2:0]  command;
        logic [15:0] entry_digits;
    } acsc_out_t;

    typedef struct packed {
        logic [5:0] snooze_minutes;
        logic [7:0] idle_timeout_seconds;
        logic [3:0] hold_seconds;
    } acsc_cfg_t;

    // Step a BCD pair up, wrapping past the limit to zero
    function automatic logic [7:0] bcd_up(input logic [7:0] pair, input logic [3:0] lt,
                                          input logic [3:0] lu);
        logic [3:0] t;
        logic [4:0] u;
        t = pair[7:4];
        u = {1'b0, pair[3:0]} + 5'd1;
        if (t >= lt && u > {1'b0, lu})
        begin
            t = 4'd0;
            u = 5'd0;
        end
        if (u > 5'd9)
        begin
            u = 5'd0;
            t = t + 4'd1;
        end
        return {t, u[3:0]};
    endfunction

    // Step a BCD pair down, wrapping below zero to the limit
    function automatic logic [7:0] bcd_down(input logic [7:0] pair, input logic [3:0] lt,
                                            input logic [3:0] lu);
        logic [3:0] t;
        logic [3:0] u;
        t = pair[7:4];
        u = pair[3:0] - 4'd1;
        if (u > 4'd9)
        begin
            u = 4'd9;
            t = t - 4'd1;
        end
        if (t >= lt && u >= lu)
        begin
            t = lt;
            u = lu;
        end
        return {t, u};
    endfunction

    // Snooze minutes as BCD in the low byte, clamped to 59
    function automatic logic [15:0] snooze_bcd(input logic [5:0] minutes);
        logic [5:0] m;
        logic [3:0] tens;
        logic [5:0] ones;
        m = (minutes > SNOOZE_MAX) ? SNOOZE_MAX : minutes;
        if (m >= 6'd50)
            tens = 4'd5;
        else if (m >= 6'd40)
            tens = 4'd4;
        else if (m >= 6'd30)
            tens = 4'd3;
        else if (m >= 6'd20)
            tens = 4'd2;
        else if (m >= 6'd10)
            tens = 4'd1;
        else
            tens = 4'd0;
        ones = m - ({2'b00, tens} * 6'd10);
        return {8'h00, tens, ones[3:0]};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/acsc_core.sv =====
// Mode machine, key edge detection, entry editing and timers of the set controller.
`default_nettype none

module acsc_core
    import acsc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      take,
    input  wire acsc_in_t  item,
    input  wire acsc_cfg_t cfg,
    output acsc_out_t      result
);

    acsc_mode_t  mode_reg, mode_next;
    logic        ringing_reg, ringing_next;
    logic [15:0] entry_reg, entry_next;
    logic [5:0]  last_keys_reg, last_keys_next;
    logic [7:0]  idle_count_reg, idle_count_next;
    logic        idle_restart_reg, idle_restart_next;
    logic [3:0]  time_hold_reg, time_hold_next;
    logic [3:0]  alarm_hold_reg, alarm_hold_next;
    acsc_cmd_t   cmd;
    logic [5:0]  key_edge;
    logic [3:0]  hold_load;

    assign key_edge  = item.key_levels & ~last_keys_reg;
    assign hold_load = (cfg.hold_seconds != 4'd0) ? cfg.hold_seconds : 4'd1;

    // Work out the next state and the command, in the order keys and timers act
    always_comb
    begin
        mode_next         = mode_reg;
        ringing_next      = ringing_reg;
        entry_next        = entry_reg;
        last_keys_next    = last_keys_reg;
        idle_count_next   = idle_count_reg;
        idle_restart_next = idle_restart_reg;
        time_hold_next    = time_hold_reg;
        alarm_hold_next   = alarm_hold_reg;
        cmd               = CMD_NONE;

        unique case (acsc_op_t'(item.operation))
            OP_KEY:
            begin
                last_keys_next = item.key_levels;

                // Accept: snooze a ringing alarm, else arm in show mode or step the mode machine
                if (key_edge[KEY_ACCEPT])
                begin
                    idle_restart_next = 1'b1;
                    if (ringing_next)
                    begin
                        ringing_next = 1'b0;
                        cmd = CMD_SNOOZE;
                    end
                    else
                    begin
                        unique case (mode_next)
                            MODE_SHOW:  cmd = CMD_ARM;
                            MODE_TMIN:  mode_next = MODE_THOUR;
                            MODE_THOUR:
                            begin
                                cmd = CMD_WRITE_TIME;
                                mode_next = MODE_SHOW;
                            end
                            MODE_AMIN:  mode_next = MODE_AHOUR;
                            MODE_AHOUR:
                            begin
                                cmd = CMD_WRITE_ALARM;
                                mode_next = MODE_SHOW;
                            end
                            default:    ;
                        endcase
                    end
                end

                // Cancel: silence, disarm, or drop the edit
                if (key_edge[KEY_CANCEL])
                begin
                    if (ringing_next)
                        ringing_next = 1'b0;
                    else if (mode_next == MODE_SHOW)
                    begin
                        if (cmd == CMD_NONE)
                            cmd = CMD_DISARM;
                    end
                    else
                    begin
                        entry_next = item.clock_time;
                        mode_next  = item.time_valid ? MODE_SHOW : MODE_UNCONF;
                    end
                end

                // Up and down: adjust the pair being edited
                if (key_edge[KEY_UP])
                begin
                    idle_restart_next = 1'b1;
                    if (mode_next == MODE_TMIN || mode_next == MODE_AMIN)
                        entry_next[7:0] = bcd_up(entry_next[7:0], MIN_TENS_MAX, MIN_UNITS_MAX);
                    else if (mode_next == MODE_THOUR || mode_next == MODE_AHOUR)
                        entry_next[15:8] = bcd_up(entry_next[15:8], HOUR_TENS_MAX,
                                                  HOUR_UNITS_MAX);
                end
                if (key_edge[KEY_DOWN])
                begin
                    idle_restart_next = 1'b1;
                    if (mode_next == MODE_TMIN || mode_next == MODE_AMIN)
                        entry_next[7:0] = bcd_down(entry_next[7:0], MIN_TENS_MAX,
                                                   MIN_UNITS_MAX);
                    else if (mode_next == MODE_THOUR || mode_next == MODE_AHOUR)
                        entry_next[15:8] = bcd_down(entry_next[15:8], HOUR_TENS_MAX,
                                                    HOUR_UNITS_MAX);
                end

                // Set keys: (re)start their hold counts
                if (key_edge[KEY_SET_TIME])
                    time_hold_next = hold_load;
                if (key_edge[KEY_SET_ALARM])
                    alarm_hold_next = hold_load;
            end

            OP_TICK:
            begin
                // Idle counter, firing a cancel on reaching the timeout
                if (mode_next == MODE_UNCONF || mode_next == MODE_SHOW || idle_restart_next)
                begin
                    idle_count_next   = 8'd0;
                    idle_restart_next = 1'b0;
                end
                else if (idle_count_next != 8'hFF)
                begin
                    idle_count_next = idle_count_next + 8'd1;
                    if (idle_count_next == cfg.idle_timeout_seconds)
                    begin
                        if (ringing_next)
                            ringing_next = 1'b0;
                        else
                        begin
                            entry_next = item.clock_time;
                            mode_next  = item.time_valid ? MODE_SHOW : MODE_UNCONF;
                        end
                    end
                end

                // Hold counts: enter set mode if the key is still down
                if (time_hold_next != 4'd0)
                begin
                    time_hold_next = time_hold_next - 4'd1;
                    if (time_hold_next == 4'd0)
                    begin
                        idle_restart_next = 1'b1;
                        if (last_keys_next[KEY_SET_TIME])
                        begin
                            mode_next  = MODE_TMIN;
                            entry_next = item.clock_time;
                        end
                    end
                end
                if (alarm_hold_next != 4'd0)
                begin
                    alarm_hold_next = alarm_hold_next - 4'd1;
                    if (alarm_hold_next == 4'd0)
                    begin
                        idle_restart_next = 1'b1;
                        if (last_keys_next[KEY_SET_ALARM])
                        begin
                            mode_next  = MODE_AMIN;
                            entry_next = item.alarm_time;
                        end
                    end
                end
            end

            OP_ALARM:
                ringing_next = 1'b1;

            OP_NONE:
                ;
        endcase
    end

    // Form the result transaction from the new state
    always_comb
    begin
        result.mode          = mode_next;
        result.alarm_ringing = ringing_next;
        result.command       = cmd;
        if (cmd == CMD_SNOOZE)
            result.entry_digits = snooze_bcd(cfg.snooze_minutes);
        else
            result.entry_digits = entry_next;
    end

    // Commit the state on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_UNCONF;
            ringing_reg      <= 1'b0;
            entry_reg        <= 16'd0;
            last_keys_reg    <= 6'd0;
            idle_count_reg   <= 8'd0;
            idle_restart_reg <= 1'b0;
            time_hold_reg    <= 4'd0;
            alarm_hold_reg   <= 4'd0;
        end
        else if (take)
        begin
            mode_reg         <= mode_next;
            ringing_reg      <= ringing_next;
            entry_reg        <= entry_next;
            last_keys_reg    <= last_keys_next;
            idle_count_reg   <= idle_count_next;
            idle_restart_reg <= idle_restart_next;
            time_hold_reg    <= time_hold_next;
            alarm_hold_reg   <= alarm_hold_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/acsc_skid.sv =====
// Result register with a skid stage, so input is taken while a result waits.
`default_nettype none

module acsc_skid
    import acsc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      take,
    input  wire acsc_out_t next_result,
    output logic           full,
    output logic           result_valid,
    input  wire logic      result_stall,
    output acsc_out_t      result
);

`include "alarm_clock_set_controller_assert.svh"

    logic      out_valid_reg, out_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    acsc_out_t out_reg;
    acsc_out_t skid_reg;
    logic      out_take;

    assign out_take     = out_valid_reg && !result_stall;
    assign full         = skid_valid_reg;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Decide where the new transaction lands and when the skid drains
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (take)
        begin
            if (!out_valid_reg || out_take)
                out_valid_next = 1'b1;
            else
                skid_valid_next = 1'b1;
        end
        else if (skid_valid_reg && out_take)
            skid_valid_next = 1'b0;
        else if (out_take)
            out_valid_next = 1'b0;
    end

    // Hold control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Move payload into the output and skid registers
    always_ff @(posedge clk)
    begin
        if (take && (!out_valid_reg || out_take))
            out_reg <= next_result;
        else if (skid_valid_reg && out_take)
            out_reg <= skid_reg;
        if (take && out_valid_reg && !out_take)
            skid_reg <= next_result;
    end

    `ACSC_ASSERT_IMP(a_skid_implies_out, skid_valid_reg, out_valid_reg)
    `ACSC_ASSERT_NXT(a_blocked_goes_to_skid, take && out_valid_reg && !out_take, skid_valid_reg)
    `ACSC_ASSERT_NXT(a_skid_drains, skid_valid_reg && out_take, !skid_valid_reg && out_valid_reg)

endmodule

`default_nettype wire

// ===== rtl/alarm_clock_set_controller.sv =====
// Top level of the alarm clock set controller: configuration registers and channels.
`default_nettype none

// Set controller of a digital alarm clock. Each item (key sample, one-second
// tick or alarm-fired event) yields exactly one result transaction, registered
// in the result register or, while that is held, in the skid register. One item
// per cycle is sustained while item_stall is low; the rate is set by the
// single-pass next-state logic feeding the result register. A skid stage behind
// the result register keeps the input open while one result waits: item_stall
// rises only when two results are held. Configuration writes (snooze minutes,
// idle timeout, hold seconds) are to be made while no result is outstanding.
module alarm_clock_set_controller
    import acsc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   item_valid,
    output logic                        item_stall,
    input  wire acsc_in_t               item,
    output logic                        result_valid,
    input  wire logic                   result_stall,
    output acsc_out_t                   result,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    acsc_cfg_t cfg_reg;
    acsc_out_t next_result;
    logic      take;
    logic      full;

    assign take       = item_valid && !full;
    assign item_stall = full;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.snooze_minutes       <= SNOOZE_RESET;
            cfg_reg.idle_timeout_seconds <= IDLE_RESET;
            cfg_reg.hold_seconds         <= HOLD_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_SNOOZE_MINUTES: cfg_reg.snooze_minutes       <= cfg_data[5:0];
                CFG_IDLE_TIMEOUT:   cfg_reg.idle_timeout_seconds <= cfg_data;
                CFG_HOLD_SECONDS:   cfg_reg.hold_seconds         <= cfg_data[3:0];
                default:            ;
            endcase
        end
    end

    acsc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .item   (item),
        .cfg    (cfg_reg),
        .result (next_result)
    );

    acsc_skid u_skid (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .next_result  (next_result),
        .full         (full),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire
